/* src/irprms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irprms_pkg
// Shared constants, command/status types and helpers for the IR pointer mapper.
// ----------------------------------------------------------------------------
package irprms_pkg;

    localparam int CAMERA_MAX_X = 560;
    localparam int CAMERA_MAX_Y = 420;
    localparam int HALF_X       = CAMERA_MAX_X / 2;
    localparam int HALF_Y       = CAMERA_MAX_Y / 2;

    // sine polynomial coefficients, Q.30
    localparam logic [30:0] SIN_A1 = 31'd1686629713;
    localparam logic [30:0] SIN_A3 = 31'd693598669;
    localparam logic [30:0] SIN_A5 = 31'd85569306;
    localparam logic [30:0] SIN_A7 = 31'd5026995;

    localparam int DIV_W     = 41;
    localparam int DIVISOR_W = 14;

    // configuration register indexes
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MARGIN_X      = 3'd2;
    localparam logic [2:0] REG_MARGIN_Y      = 3'd3;
    localparam logic [2:0] REG_ORIGIN_X      = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Y      = 3'd5;

    typedef logic [4:0] op_t;

    localparam op_t OP_NONE = 5'd0;
    localparam op_t OP_LOAD = 5'd1;
    localparam op_t OP_X2   = 5'd2;
    localparam op_t OP_P1   = 5'd3;
    localparam op_t OP_P2   = 5'd4;
    localparam op_t OP_P3   = 5'd5;
    localparam op_t OP_PR   = 5'd6;
    localparam op_t OP_R1   = 5'd7;
    localparam op_t OP_R2   = 5'd8;
    localparam op_t OP_R3   = 5'd9;
    localparam op_t OP_R4   = 5'd10;
    localparam op_t OP_G0   = 5'd11;
    localparam op_t OP_G1   = 5'd12;
    localparam op_t OP_G2   = 5'd13;
    localparam op_t OP_G3   = 5'd14;
    localparam op_t OP_M0   = 5'd15;
    localparam op_t OP_M1   = 5'd16;
    localparam op_t OP_M2   = 5'd17;
    localparam op_t OP_OUT  = 5'd18;

    typedef struct packed {
        op_t  op;
        logic axis;   // 0 x, 1 y
        logic sel;    // 0 sine argument, 1 cosine argument
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic div_busy;
        logic div_done;
        logic out_free;
    } sts_t;

    function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
        logic signed [23:0] r;
        begin
            if (v > 44'sd8388607)
                r = 24'sh7FFFFF;
            else if (v < -44'sd8388608)
                r = 24'sh800000;
            else
                r = v[23:0];
            return r;
        end
    endfunction

endpackage

/* src/irprms_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irprms_in_if
// Request channel carrying one camera sample or tick.
// ----------------------------------------------------------------------------
interface irprms_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [10:0] camera_x;
    logic signed [10:0] camera_y;
    logic [15:0]        roll_angle;

    modport source (output valid, action, camera_x, camera_y, roll_angle, input ready);
    modport sink   (input valid, action, camera_x, camera_y, roll_angle, output ready);
endinterface

/* src/irprms_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irprms_out_if
// Result channel carrying the smoothed cursor.
// ----------------------------------------------------------------------------
interface irprms_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] cursor_x;
    logic signed [23:0] cursor_y;
    logic signed [23:0] desktop_x;
    logic signed [23:0] desktop_y;
    logic [15:0]        applied_angle;

    modport source (output valid, cursor_x, cursor_y, desktop_x, desktop_y, applied_angle,
                     input ready);
    modport sink   (input valid, cursor_x, cursor_y, desktop_x, desktop_y, applied_angle,
                     output ready);
endinterface

/* src/irprms_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irprms_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface irprms_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  idx;
    logic [14:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

/* src/irprms_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irprms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module irprms_div
    import irprms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic [DIV_W-1:0]     quotient,
    output logic                 busy,
    output logic                 done
);

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIVISOR_W'(trial - {1'b0, dsr_reg}) : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            dsr_reg <= divisor;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

endmodule

/* src/irprms_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irprms_dp
// Datapath: registers, sine polynomial, rotation, screen mapping, smoothing.
// ----------------------------------------------------------------------------
module irprms_dp
    import irprms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               in_action,
    input  logic signed [10:0] in_camera_x,
    input  logic signed [10:0] in_camera_y,
    input  logic [15:0]        in_roll_angle,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [14:0]        cfg_data,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [23:0] cursor_x,
    output logic signed [23:0] cursor_y,
    output logic signed [23:0] desktop_x,
    output logic signed [23:0] desktop_y,
    output logic [15:0]        applied_angle
);

    // configuration
    logic [13:0]        sw_reg, sh_reg;
    logic [8:0]         mx_reg;
    logic [7:0]         my_reg;
    logic signed [14:0] ox_reg, oy_reg;

    // state
    logic [9:0]         tx_reg;
    logic [8:0]         ty_reg;
    logic [15:0]        tang_reg;
    logic signed [23:0] curx_reg, cury_reg;

    // working registers
    logic [15:0]        x2_reg;
    logic [30:0]        p_reg;
    logic [31:0]        s_reg, c_reg;
    logic signed [44:0] rx_reg, ry_reg;
    logic signed [45:0] num_reg;
    logic signed [60:0] np_reg;
    logic               neg_reg;
    logic signed [23:0] goal_reg;
    logic [24:0]        mag_reg;

    logic               out_valid_reg;
    logic signed [23:0] ocx_reg, ocy_reg, odx_reg, ody_reg;
    logic [15:0]        oang_reg;

    logic [15:0]        theta;
    logic [14:0]        qarg;
    logic [30:0]        ua;
    logic [15:0]        ub;
    logic [46:0]        umul;
    logic signed [32:0] s33, c33, sn, cs;
    logic signed [10:0] dx, dy, ra;
    logic signed [32:0] rb;
    logic signed [43:0] rmul;

    logic signed [44:0] rot;
    logic [8:0]         half9, marg9;
    logic [10:0]        cammax;
    logic signed [10:0] hm;
    logic signed [40:0] hm_sh;
    logic signed [11:0] span_raw;
    logic [9:0]         span;
    logic [13:0]        size, sz;
    logic signed [14:0] sz_s;
    logic signed [60:0] gmul;
    logic signed [38:0] a39;
    logic signed [40:0] a41;
    logic [40:0]        fmag;
    logic signed [23:0] cur;
    logic signed [24:0] diff;
    logic [49:0]        sq;
    logic [DIV_W-1:0]   quo;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic               div_busy, div_done;
    logic signed [43:0] sgn_q;
    logic signed [23:0] new_cur;

    assign theta = 16'(16'd0 - tang_reg);
    assign qarg  = cmd.sel ? 15'(15'd16384 - {1'b0, theta[13:0]}) : {1'b0, theta[13:0]};

    // shared unsigned multiplier for the sine polynomial
    always_comb
    begin
        ua = p_reg;
        ub = x2_reg;
        unique case (cmd.op)
            OP_X2:
            begin
                ua = 31'(qarg);
                ub = 16'(qarg);
            end
            OP_P1:   ua = SIN_A7;
            OP_PR:   ub = 16'(qarg);
            default: ua = p_reg;
        endcase
    end
    assign umul = 47'(ua) * 47'(ub);

    // quadrant fold
    assign s33 = $signed({1'b0, s_reg});
    assign c33 = $signed({1'b0, c_reg});
    always_comb
    begin
        case (theta[15:14])
            2'd0:    begin sn = s33;  cs = c33;  end
            2'd1:    begin sn = c33;  cs = -s33; end
            2'd2:    begin sn = -s33; cs = -c33; end
            default: begin sn = -c33; cs = s33;  end
        endcase
    end

    assign dx = $signed({1'b0, tx_reg}) - 11'(HALF_X);
    assign dy = $signed({2'b0, ty_reg}) - 11'(HALF_Y);
    assign ra = (cmd.op == OP_R1 || cmd.op == OP_R3) ? dx : dy;
    assign rb = (cmd.op == OP_R1 || cmd.op == OP_R4) ? cs : sn;
    assign rmul = 44'(ra) * 44'(rb);

    // per-axis selection
    assign rot      = cmd.axis ? ry_reg : rx_reg;
    assign half9    = cmd.axis ? 9'(HALF_Y) : 9'(HALF_X);
    assign marg9    = cmd.axis ? {1'b0, my_reg} : mx_reg;
    assign cammax   = cmd.axis ? 11'(CAMERA_MAX_Y) : 11'(CAMERA_MAX_X);
    assign hm       = $signed({2'b0, half9}) - $signed({2'b0, marg9});
    assign hm_sh    = {hm, 30'b0};
    assign span_raw = $signed({1'b0, cammax}) - $signed({2'b0, marg9, 1'b0});
    assign span     = (span_raw < 12'sd1) ? 10'd1 : span_raw[9:0];
    assign size     = cmd.axis ? sh_reg : sw_reg;
    assign sz       = (size == 14'd0) ? 14'd1 : size;
    assign sz_s     = $signed({1'b0, sz});
    assign gmul     = 61'(num_reg) * 61'(sz_s);
    assign a39      = np_reg[60:22];
    assign a41      = 41'(a39);
    assign fmag     = a39[38] ? 41'(41'd0 - a41 + 41'(span) - 41'd1) : a41;
    assign cur      = cmd.axis ? cury_reg : curx_reg;
    assign diff     = 25'(cur) - 25'(goal_reg);
    assign sq       = 50'(mag_reg) * 50'(mag_reg);
    assign sgn_q    = neg_reg ? -44'(quo) : 44'(quo);
    assign new_cur  = sat24(44'(cur) - sgn_q);

    assign div_start    = (cmd.op == OP_G2) || (cmd.op == OP_M1);
    assign div_dividend = (cmd.op == OP_G2) ? fmag : sq[48:8];
    assign div_divisor  = (cmd.op == OP_G2) ? {4'b0, span} : sz;

    irprms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quo),
        .busy     (div_busy),
        .done     (div_done)
    );

    assign sts.drop = !in_action &&
        (in_camera_x[10] || in_camera_y[10] ||
         in_camera_x[9:0] > 10'(CAMERA_MAX_X) || in_camera_y[9:0] > 10'(CAMERA_MAX_Y));
    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || out_ready;

    // configuration and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg        <= 14'd2560;
            sh_reg        <= 14'd1440;
            mx_reg        <= 9'd40;
            my_reg        <= 8'd20;
            ox_reg        <= '0;
            oy_reg        <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            tang_reg      <= '0;
            curx_reg      <= '0;
            cury_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_SCREEN_WIDTH:  sw_reg <= cfg_data[13:0];
                    REG_SCREEN_HEIGHT: sh_reg <= cfg_data[13:0];
                    REG_MARGIN_X:      mx_reg <= cfg_data[8:0];
                    REG_MARGIN_Y:      my_reg <= cfg_data[7:0];
                    REG_ORIGIN_X:      ox_reg <= $signed(cfg_data);
                    REG_ORIGIN_Y:      oy_reg <= $signed(cfg_data);
                    default:           ;
                endcase
            end
            if (cmd.op == OP_LOAD && !in_action)
            begin
                tx_reg   <= in_camera_x[9:0];
                ty_reg   <= in_camera_y[8:0];
                tang_reg <= in_roll_angle;
            end
            if (cmd.op == OP_M2)
            begin
                if (cmd.axis)
                    cury_reg <= new_cur;
                else
                    curx_reg <= new_cur;
            end
            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_X2: x2_reg <= umul[29:14];
            OP_P1: p_reg  <= SIN_A5 - umul[44:14];
            OP_P2: p_reg  <= SIN_A3 - umul[44:14];
            OP_P3: p_reg  <= SIN_A1 - umul[44:14];
            OP_PR:
            begin
                if (cmd.sel)
                    c_reg <= umul[45:14];
                else
                    s_reg <= umul[45:14];
            end
            OP_R1: rx_reg <= 45'(rmul);
            OP_R2: rx_reg <= rx_reg - 45'(rmul);
            OP_R3: ry_reg <= 45'(rmul);
            OP_R4: ry_reg <= ry_reg + 45'(rmul);
            OP_G0: num_reg <= 46'(rot) + 46'(hm_sh);
            OP_G1: np_reg  <= gmul + 61'($signed({1'b0, span, 21'b0}));
            OP_G2: neg_reg <= a39[38];
            OP_G3: goal_reg <= sat24(sgn_q);
            OP_M0:
            begin
                neg_reg <= diff[24];
                mag_reg <= diff[24] ? 25'(-diff) : 25'(diff);
            end
            OP_OUT:
            begin
                ocx_reg  <= curx_reg;
                ocy_reg  <= cury_reg;
                odx_reg  <= sat24(44'(curx_reg) + 44'($signed({ox_reg, 8'b0})));
                ody_reg  <= sat24(44'(cury_reg) + 44'($signed({oy_reg, 8'b0})));
                oang_reg <= theta;
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign cursor_x      = ocx_reg;
    assign cursor_y      = ocy_reg;
    assign desktop_x     = odx_reg;
    assign desktop_y     = ody_reg;
    assign applied_angle = oang_reg;

endmodule

/* src/irprms_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irprms_ctrl
// Sequencer that walks the datapath through one request.
// ----------------------------------------------------------------------------
module irprms_ctrl
    import irprms_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_X2   = 5'd1;
    localparam logic [4:0] ST_P1   = 5'd2;
    localparam logic [4:0] ST_P2   = 5'd3;
    localparam logic [4:0] ST_P3   = 5'd4;
    localparam logic [4:0] ST_PR   = 5'd5;
    localparam logic [4:0] ST_R1   = 5'd6;
    localparam logic [4:0] ST_R2   = 5'd7;
    localparam logic [4:0] ST_R3   = 5'd8;
    localparam logic [4:0] ST_R4   = 5'd9;
    localparam logic [4:0] ST_G0   = 5'd10;
    localparam logic [4:0] ST_G1   = 5'd11;
    localparam logic [4:0] ST_G2   = 5'd12;
    localparam logic [4:0] ST_GW   = 5'd13;
    localparam logic [4:0] ST_G3   = 5'd14;
    localparam logic [4:0] ST_M0   = 5'd15;
    localparam logic [4:0] ST_M1   = 5'd16;
    localparam logic [4:0] ST_MW   = 5'd17;
    localparam logic [4:0] ST_M2   = 5'd18;
    localparam logic [4:0] ST_OUT  = 5'd19;

    logic [4:0] state_reg, state_next;
    logic       axis_reg, axis_next;
    logic       sel_reg, sel_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        cmd.sel    = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !sts.drop)
                begin
                    cmd.op     = OP_LOAD;
                    axis_next  = 1'b0;
                    sel_next   = 1'b0;
                    state_next = ST_X2;
                end
            end
            ST_X2: begin cmd.op = OP_X2; state_next = ST_P1; end
            ST_P1: begin cmd.op = OP_P1; state_next = ST_P2; end
            ST_P2: begin cmd.op = OP_P2; state_next = ST_P3; end
            ST_P3: begin cmd.op = OP_P3; state_next = ST_PR; end
            ST_PR:
            begin
                cmd.op = OP_PR;
                if (sel_reg)
                    state_next = ST_R1;
                else
                begin
                    sel_next   = 1'b1;
                    state_next = ST_X2;
                end
            end
            ST_R1: begin cmd.op = OP_R1; state_next = ST_R2; end
            ST_R2: begin cmd.op = OP_R2; state_next = ST_R3; end
            ST_R3: begin cmd.op = OP_R3; state_next = ST_R4; end
            ST_R4: begin cmd.op = OP_R4; state_next = ST_G0; end
            ST_G0: begin cmd.op = OP_G0; state_next = ST_G1; end
            ST_G1: begin cmd.op = OP_G1; state_next = ST_G2; end
            ST_G2: begin cmd.op = OP_G2; state_next = ST_GW; end
            ST_GW:
            begin
                if (sts.div_done)
                    state_next = ST_G3;
            end
            ST_G3: begin cmd.op = OP_G3; state_next = ST_M0; end
            ST_M0: begin cmd.op = OP_M0; state_next = ST_M1; end
            ST_M1: begin cmd.op = OP_M1; state_next = ST_MW; end
            ST_MW:
            begin
                if (sts.div_done)
                    state_next = ST_M2;
            end
            ST_M2:
            begin
                cmd.op = OP_M2;
                if (axis_reg)
                    state_next = ST_OUT;
                else
                begin
                    axis_next  = 1'b1;
                    state_next = ST_G0;
                end
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

/* src/ir_pointer_roll_map_smoother.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pointer_roll_map_smoother
// Roll-compensated IR pointer to screen cursor mapper with quadratic smoothing.
// ----------------------------------------------------------------------------
// Each request is a camera sample or a tick. A sample outside the camera
// frame is taken and dropped with no result and no state change; otherwise it
// becomes the stored target, and a tick replays that target. The target is
// rotated about the camera centre by the full turn minus the roll, mapped to
// the screen with the margins removed, and the Q15.8 cursor steps toward that
// goal by diff*|diff|/size on each axis. One request is worked at a time:
// the two sine evaluations on a shared multiplier, then the rotation, then
// per axis two divisions on a single bit-serial divider (screen mapping and
// smoothing step). The result register lets the next request start while
// a result waits; a dropped sample is taken straight from idle.
// Configuration writes are always taken.
// ----------------------------------------------------------------------------
module ir_pointer_roll_map_smoother
    import irprms_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    irprms_in_if.sink     in_ch,
    irprms_out_if.source  out_ch,
    irprms_cfg_if.sink    cfg
);

    cmd_t cmd;
    sts_t sts;

    // writes land directly in the datapath registers
    assign cfg.ready = 1'b1;

    irprms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    irprms_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_action     (in_ch.action),
        .in_camera_x   (in_ch.camera_x),
        .in_camera_y   (in_ch.camera_y),
        .in_roll_angle (in_ch.roll_angle),
        .cfg_we        (cfg.valid),
        .cfg_idx       (cfg.idx),
        .cfg_data      (cfg.data),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .cursor_x      (out_ch.cursor_x),
        .cursor_y      (out_ch.cursor_y),
        .desktop_x     (out_ch.desktop_x),
        .desktop_y     (out_ch.desktop_y),
        .applied_angle (out_ch.applied_angle)
    );

    // load only on an accepted request
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |-> (in_ch.valid && in_ch.ready))
        else $error("target load without accepted request");

    // never restart the divider mid-division
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_G2 || cmd.op == OP_M1) |-> !sts.div_busy)
        else $error("divider restarted while busy");

    // never overwrite a result that has not been taken
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> (!out_ch.valid || out_ch.ready))
        else $error("result overwritten before taken");

    // a result appears in the cycle after the result load
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(cmd.op == OP_OUT))
        else $error("result valid without result load");

endmodule

/* bench/ir_pointer_roll_map_smoother_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pointer_roll_map_smoother_tb
// Self-checking bench for the roll-compensated IR cursor mapper.
// ----------------------------------------------------------------------------
// A clocked driver feeds camera samples and ticks from a pending queue. A
// clocked monitor checks every cursor result against a fixed-point cursor
// predictor that runs on each accepted request. The run covers several
// register settings, the extremes among them, and mixes sender gaps,
// receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ir_pointer_roll_map_smoother_tb;
    import irprms_pkg::*;

    localparam int     HALF_PERIOD = 6;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     SETTLE      = 300;
    localparam int     HOLD_CYCLES = 3000;
    localparam int     CAM_W       = 560;
    localparam int     CAM_H       = 420;

    localparam longint K_A1 = 64'd1686629713;
    localparam longint K_A3 = 64'd693598669;
    localparam longint K_A5 = 64'd85569306;
    localparam longint K_A7 = 64'd5026995;
    localparam longint Q30  = 64'sd1 << 30;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef struct {
        logic               action;
        logic signed [10:0] cam_x;
        logic signed [10:0] cam_y;
        logic [15:0]        roll;
    } pointer_req_t;

    typedef struct {
        logic signed [23:0] cur_x;
        logic signed [23:0] cur_y;
        logic signed [23:0] desk_x;
        logic signed [23:0] desk_y;
        logic [15:0]        angle;
    } cursor_res_t;

    logic clk;
    logic rst_n;

    irprms_in_if  in_bus();
    irprms_out_if out_bus();
    irprms_cfg_if cfg_bus();

    ir_pointer_roll_map_smoother u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus),
        .cfg    (cfg_bus)
    );

    // pending requests and predicted cursors
    pointer_req_t pend_q[$];
    cursor_res_t  cursor_q[$];

    // shadow of the registers and the mapper state
    longint scr_w, scr_h, mar_x, mar_y, org_x, org_y;
    longint tgt_x, tgt_y;
    logic [15:0] tgt_angle;
    longint pos_x, pos_y;

    int     send_idle_pct;
    int     stall_pct;
    logic   hold_go;
    logic   hold_done;
    int     hold_left;
    longint cycles;
    int     errors;
    int     n_sample, n_tick, n_drop, n_result, n_cfg;

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------
    function automatic longint clip24(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    // sine of r/16384 of a quarter turn, Q.30
    function automatic longint quarter_sine(longint r);
        longint x2, p;
        x2 = (r * r) >>> 14;
        p  = K_A5 - ((K_A7 * x2) >>> 14);
        p  = K_A3 - ((p * x2) >>> 14);
        p  = K_A1 - ((p * x2) >>> 14);
        return (p * r) >>> 14;
    endfunction

    // rotated Q.30 coordinate to Q15.8 screen goal, rounded half up
    function automatic longint screen_goal(longint rot, longint half, longint margin,
                                           longint cam_max, longint size);
        longint span, sz, num, d, n;
        span = cam_max - 2 * margin;
        if (span < 1)
            span = 1;
        sz  = (size == 0) ? 1 : size;
        num = rot + half * Q30 - margin * Q30;
        d   = span * (64'sd1 << 22);
        n   = num * sz + d / 2;
        if (n >= 0)
            return clip24(n / d);
        return clip24(-((-n + d - 1) / d));
    endfunction

    // quadratic step of the cursor toward the goal
    function automatic longint damp_step(longint cur, longint goal, longint size);
        longint diff, mag, den, stp;
        diff = cur - goal;
        mag  = (diff < 0) ? -diff : diff;
        den  = ((size == 0) ? 1 : size) * 256;
        stp  = (mag * mag) / den;
        if (diff < 0)
            stp = -stp;
        return clip24(cur - stp);
    endfunction

    task automatic predict_cursor(input pointer_req_t rq);
        longint px, py, s, c, sn, cs, dx, dy, rx, ry, gx, gy;
        logic [15:0] theta;
        cursor_res_t res;
        if (rq.action == ACT_SAMPLE) begin
            px = longint'(rq.cam_x);
            py = longint'(rq.cam_y);
            // drop a point outside the camera frame, state untouched
            if (px < 0 || py < 0 || px > CAM_W || py > CAM_H) begin
                n_drop++;
                return;
            end
            n_sample++;
            tgt_x     = px;
            tgt_y     = py;
            tgt_angle = rq.roll;
        end
        else
            n_tick++;
        theta = 16'(17'h10000 - tgt_angle);
        s = quarter_sine(longint'(theta[13:0]));
        c = quarter_sine(16384 - longint'(theta[13:0]));
        case (theta[15:14])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
        dx = tgt_x - CAM_W / 2;
        dy = tgt_y - CAM_H / 2;
        rx = dx * cs - dy * sn;
        ry = dx * sn + dy * cs;
        gx = screen_goal(rx, CAM_W / 2, mar_x, CAM_W, scr_w);
        gy = screen_goal(ry, CAM_H / 2, mar_y, CAM_H, scr_h);
        pos_x = damp_step(pos_x, gx, scr_w);
        pos_y = damp_step(pos_y, gy, scr_h);
        res.cur_x  = 24'(pos_x);
        res.cur_y  = 24'(pos_y);
        res.desk_x = 24'(clip24(pos_x + org_x * 256));
        res.desk_y = 24'(clip24(pos_y + org_y * 256));
        res.angle  = theta;
        cursor_q.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // Request driver: advance only when the current request is taken
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : drive_req
        pointer_req_t rq;
        if (!rst_n)
            in_bus.valid <= 1'b0;
        else if (!in_bus.valid || in_bus.ready) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                rq = pend_q.pop_front();
                in_bus.valid      <= 1'b1;
                in_bus.action     <= rq.action;
                in_bus.camera_x   <= rq.cam_x;
                in_bus.camera_y   <= rq.cam_y;
                in_bus.roll_angle <= rq.roll;
            end
            else
                in_bus.valid <= 1'b0;
        end
    end

    // long hold-off of the receiver, counted here
    always @(posedge clk) begin
        if (hold_go && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // receiver: stall at random, hold low during the hold-off
    always @(posedge clk) begin
        if (!rst_n)
            out_bus.ready <= 1'b0;
        else
            out_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on accepted requests, check accepted results
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : watch
        pointer_req_t rq;
        cursor_res_t  want;
        if (rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                n_cfg++;
                case (cfg_bus.idx)
                    REG_SCREEN_WIDTH:  scr_w = longint'(cfg_bus.data[13:0]);
                    REG_SCREEN_HEIGHT: scr_h = longint'(cfg_bus.data[13:0]);
                    REG_MARGIN_X:      mar_x = longint'(cfg_bus.data[8:0]);
                    REG_MARGIN_Y:      mar_y = longint'(cfg_bus.data[7:0]);
                    REG_ORIGIN_X:      org_x = longint'($signed(cfg_bus.data));
                    REG_ORIGIN_Y:      org_y = longint'($signed(cfg_bus.data));
                    default: ;
                endcase
            end
            if (in_bus.valid && in_bus.ready) begin
                rq.action = in_bus.action;
                rq.cam_x  = in_bus.camera_x;
                rq.cam_y  = in_bus.camera_y;
                rq.roll   = in_bus.roll_angle;
                predict_cursor(rq);
            end
            if (out_bus.valid && out_bus.ready) begin
                n_result++;
                if (cursor_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: cursor result with none pending at %0t", $realtime);
                end
                else begin
                    want = cursor_q.pop_front();
                    if (out_bus.cursor_x !== want.cur_x || out_bus.cursor_y !== want.cur_y
                        || out_bus.desktop_x !== want.desk_x
                        || out_bus.desktop_y !== want.desk_y
                        || out_bus.applied_angle !== want.angle) begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: result %0d exp cur=(%0d,%0d) desk=(%0d,%0d) ang=%0d got cur=(%0d,%0d) desk=(%0d,%0d) ang=%0d",
                                     n_result, want.cur_x, want.cur_y, want.desk_x,
                                     want.desk_y, want.angle, out_bus.cursor_x,
                                     out_bus.cursor_y, out_bus.desktop_x,
                                     out_bus.desktop_y, out_bus.applied_angle);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input longint value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.idx   <= idx;
        cfg_bus.data  <= 15'(value);
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic load_regs(input longint w, input longint h, input longint mx,
                             input longint my, input longint ox, input longint oy);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_MARGIN_X, mx);
        write_reg(REG_MARGIN_Y, my);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
    endtask

    task automatic push_req(input logic act, input int x, input int y, input int roll);
        pointer_req_t rq;
        rq.action = act;
        rq.cam_x  = 11'(x);
        rq.cam_y  = 11'(y);
        rq.roll   = 16'(roll);
        pend_q.push_back(rq);
    endtask

    // mostly in-frame samples with random content, some ticks, some noise
    task automatic push_random(input int count);
        int k, sel;
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 65)
                push_req(ACT_SAMPLE, $urandom_range(CAM_W), $urandom_range(CAM_H),
                         $urandom_range(65535));
            else if (sel < 70)
                push_req(ACT_SAMPLE, ($urandom_range(1) != 0) ? CAM_W : 0,
                         ($urandom_range(1) != 0) ? CAM_H : 0, $urandom_range(65535));
            else if (sel < 85)
                push_req(ACT_TICK, $urandom_range(2047), $urandom_range(2047),
                         $urandom_range(65535));
            else
                push_req(ACT_SAMPLE, $urandom_range(2047), $urandom_range(2047),
                         $urandom_range(65535));
        end
    endtask

    // drain everything, then let a dropped sample settle before any write
    task automatic drain;
        while (pend_q.size() != 0 || in_bus.valid || cursor_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial begin
        int ph;
        clk = 1'b0;
        rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.action = ACT_SAMPLE;
        in_bus.camera_x = '0;
        in_bus.camera_y = '0;
        in_bus.roll_angle = '0;
        out_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.idx = '0;
        cfg_bus.data = '0;
        scr_w = 2560; scr_h = 1440; mar_x = 40; mar_y = 20; org_x = 0; org_y = 0;
        tgt_x = 0; tgt_y = 0; tgt_angle = '0; pos_x = 0; pos_y = 0;
        send_idle_pct = 0; stall_pct = 0;
        hold_go = 1'b0; hold_done = 1'b0; hold_left = 0;
        cycles = 0; errors = 0;
        n_sample = 0; n_tick = 0; n_drop = 0; n_result = 0; n_cfg = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, no idling
        push_req(ACT_TICK, 0, 0, 0);                 // tick before any sample
        push_req(ACT_SAMPLE, 0, 0, 0);
        push_req(ACT_SAMPLE, CAM_W, CAM_H, 65535);
        push_req(ACT_SAMPLE, CAM_W + 1, 0, 100);     // just outside x
        push_req(ACT_SAMPLE, 0, CAM_H + 1, 100);     // just outside y
        push_req(ACT_SAMPLE, -1, 5, 100);
        push_req(ACT_SAMPLE, 5, -1, 100);
        push_req(ACT_SAMPLE, -1024, -1024, 0);
        push_req(ACT_SAMPLE, 1023, 1023, 65535);
        push_req(ACT_SAMPLE, CAM_W / 2, CAM_H / 2, 16384);
        push_req(ACT_SAMPLE, CAM_W, 0, 32768);
        push_req(ACT_SAMPLE, 0, CAM_H, 49152);
        push_req(ACT_SAMPLE, 511, 255, 1);
        push_req(ACT_TICK, 1023, 1023, 65535);
        push_req(ACT_TICK, 0, 0, 0);
        push_req(ACT_SAMPLE, 256, 400, 21845);
        push_req(ACT_SAMPLE, 100, 300, 43690);
        push_req(ACT_TICK, 0, 0, 0);
        drain();

        // registers past the last index are ignored
        write_reg(3'd6, 15'h7FFF);
        write_reg(3'd7, 15'h1234);

        for (ph = 0; ph < 9; ph++) begin
            case (ph)
                0: load_regs(8192, 8192, 0, 0, 16383, -16384);
                1: load_regs(1, 1, 279, 209, -16384, 16383);
                2: load_regs(0, 0, 300, 230, 0, 0);       // zero size, margin too wide
                3: load_regs(1920, 1080, 40, 20, 1920, -500);
                4: load_regs(511, 255, 511, 255, -1, 1); // widest margin codes
                default: load_regs($urandom_range(1, 8192), $urandom_range(1, 8192),
                                   $urandom_range(279), $urandom_range(209),
                                   int'($urandom_range(32767)) - 16384,
                                   int'($urandom_range(32767)) - 16384);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            // hold the receiver off while requests keep coming
            if (ph == 3)
                hold_go <= 1'b1;
            push_random(85);
            drain();
        end

        $display("Run: %0d samples, %0d ticks, %0d dropped points, %0d results checked",
                 n_sample, n_tick, n_drop, n_result);
        $display("Run: %0d register writes over ten register settings", n_cfg);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
src/irprms_pkg.sv
src/irprms_in_if.sv
src/irprms_out_if.sv
src/irprms_cfg_if.sv
src/irprms_div.sv
src/irprms_dp.sv
src/irprms_ctrl.sv
src/ir_pointer_roll_map_smoother.sv
bench/ir_pointer_roll_map_smoother_tb.sv
